// ===== hdl/gedc_pkg.sv =====
// Shared types and constants for the Gilbert-Elliott delay channel unit.
// No dependencies; the unit, the twister and the testbench refer to this package by scoped names.
package gedc_pkg;

   // Item function codes
   localparam logic [1:0] FUNC_TRANSMIT = 2'd0;
   localparam logic [1:0] FUNC_FLUSH    = 2'd1;
   localparam logic [1:0] FUNC_CLEAR    = 2'd2;
   // unused code, handled like a flush
   localparam logic [1:0] FUNC_SPARE    = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] CSR_PROB_G2B  = 3'd0;
   localparam logic [2:0] CSR_PROB_B2G  = 3'd1;
   localparam logic [2:0] CSR_LOSS_GOOD = 3'd2;
   localparam logic [2:0] CSR_LOSS_BAD  = 3'd3;
   localparam logic [2:0] CSR_DELAY     = 3'd4;
   localparam logic [2:0] CSR_SEED      = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int PROB_W      = 33;

   // Results emitted per item at most
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // 64-bit Mersenne twister constants
   localparam int          TW_N       = 312;
   localparam int          TW_M       = 156;
   localparam int          TW_IDX_W   = $clog2(TW_N);
   localparam logic [63:0] TW_MATRIX  = 64'hB502_6F5A_A966_19E9;
   localparam logic [31:0] TW_MUL_LO  = 32'h4C95_7F2D;
   localparam logic [31:0] TW_MUL_HI  = 32'h5851_F42D;
   localparam logic [63:0] TW_DEF_SEED = 64'd5489;

   typedef struct packed {
      logic              start;
      logic [PROB_W-1:0] prob;
   } gedc_draw_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic hit;
   } gedc_draw_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAW_STATE,
      ST_DRAW_LOSS,
      ST_PUSH,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } gedc_state_type;

   typedef enum logic [3:0] {
      TW_SEED_INIT,
      TW_MUL_LO_ST,
      TW_MUL_MID_ST,
      TW_MUL_CROSS_ST,
      TW_SEED_WRITE,
      TW_IDLE,
      TW_READ_SELF,
      TW_READ_NEXT,
      TW_READ_FAR,
      TW_UPDATE
   } gedc_tw_state_type;

endpackage

// ===== hdl/gedc_req_if.sv =====
// Input channel of the delay channel unit: valid/ready plus item fields.
// No dependencies.
interface gedc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [30:0] step_number;
   logic [31:0] payload_tag;

   modport source (output valid, func, step_number, payload_tag, input ready);
   modport sink   (input valid, func, step_number, payload_tag, output ready);
endinterface

// ===== hdl/gedc_rsp_if.sv =====
// Result channel of the delay channel unit: valid/ready plus result fields.
// FILL_W follows the queue depth of the unit.
interface gedc_rsp_if #(parameter int FILL_W = 5);
   logic              valid;
   logic              ready;
   logic              delivered;
   logic [31:0]       arrive_step;
   logic [31:0]       payload_out;
   logic              last_of_run;
   logic              channel_bad;
   logic              packet_lost;
   logic              queue_overflow;
   logic [FILL_W-1:0] in_flight;

   modport source (output valid, delivered, arrive_step, payload_out, last_of_run,
                   channel_bad, packet_lost, queue_overflow, in_flight,
                   input ready);
   modport sink   (input valid, delivered, arrive_step, payload_out, last_of_run,
                   channel_bad, packet_lost, queue_overflow, in_flight,
                   output ready);
endinterface

// ===== hdl/gilbert_elliott_delay_channel_unit.sv =====
// Gilbert-Elliott delay channel: Markov good/bad chain, loss draw, delay queue.
// Uses gedc_pkg, gedc_req_if, gedc_rsp_if, gedc_ram and gedc_twister.
//
// req carries func, step_number and payload_tag; rsp carries one or more
// results per item, the final one flagged by last_of_run. Items with no due
// packet give a single result with delivered low. Registers are written via
// csr_write_enable / csr_index / csr_write_data; the user must write them only
// while the unit is idle, as the block does not enforce it. After reset, and
// after each seed write, the generator fills its 312 state words one by one
// through MUL_LO, MUL_MID, MUL_CROSS and SEED_WRITE, with req.ready held low.
// A transmit item makes two draws (three reads of the twister RAM and one
// writeback each), then queues the packet in ST_PUSH unless it is lost or the
// queue is full; every popped packet then passes ST_READ for the queue RAM read
// and ST_CHECK for the compare, and the run closes in ST_FINISH.
// Each popped packet waits in a holding register until the next check tells
// whether it is the last; results sit in an output register, so a stalled
// receiver only stops the unit when a second result is ready to go out.
module gilbert_elliott_delay_channel_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   gedc_req_if.sink                        req,
   gedc_rsp_if.source                      rsp,
   input  logic                            csr_write_enable,
   input  logic [gedc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gedc_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   localparam int AW    = $clog2(QUEUE_DEPTH);
   localparam int FW    = $clog2(QUEUE_DEPTH + 1);
   localparam int SW    = FW + 1;
   localparam int PW    = gedc_pkg::PROB_W;
   localparam int CW    = gedc_pkg::CNT_W;

   // configuration
   logic [PW-1:0] p_g2b_ff, p_b2g_ff, loss_good_ff, loss_bad_ff;
   logic [15:0]   delay_ff;
   logic [63:0]   seed_ff;
   logic          seed_load;

   gedc_pkg::gedc_state_type state_ff, state_in;

   logic [1:0]    func_ff;
   logic [30:0]   step_ff;
   logic [31:0]   tag_ff;
   logic          bad_ff, lost_ff, ovf_ff;
   logic [AW-1:0] head_ff;
   logic [FW-1:0] fill_ff;
   logic [CW-1:0] count_ff;

   logic          hold_v_ff;
   logic [31:0]   hold_arr_ff, hold_pay_ff;
   logic [FW-1:0] hold_fill_ff;

   logic          rsp_valid_ff, rsp_delivered_ff, rsp_last_ff;
   logic          rsp_bad_ff, rsp_lost_ff, rsp_ovf_ff;
   logic [31:0]   rsp_arr_ff, rsp_pay_ff;
   logic [FW-1:0] rsp_pending_ff;

   gedc_pkg::gedc_draw_req_type draw_req;
   gedc_pkg::gedc_draw_rsp_type draw_rsp;

   logic          accept, out_free, queue_full, due, bad_next;
   logic          q_we, take, emit_hold, emit_final;
   logic [SW-1:0] slot_sum;
   logic [AW-1:0] slot, head_inc;
   logic [63:0]   q_rdata;
   logic [31:0]   q_arr;

   gedc_twister u_twister (
      .clock     (clock),
      .reset     (reset),
      .seed_load (seed_load),
      .seed      (seed_ff),
      .draw_req  (draw_req),
      .draw_rsp  (draw_rsp)
   );

   gedc_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (slot),
      .wr_data ({32'(step_ff) + 32'(delay_ff), tag_ff}),
      .rd_addr (head_ff),
      .rd_data (q_rdata)
   );

   always_comb begin
      accept     = req.valid && req.ready;
      out_free   = !rsp_valid_ff || rsp.ready;
      queue_full = (fill_ff == FW'(QUEUE_DEPTH));
      q_arr      = q_rdata[63:32];
      due        = q_arr <= {1'b0, step_ff};
      bad_next   = bad_ff ^ draw_rsp.hit;
      slot_sum   = SW'(head_ff) + SW'(fill_ff);
      slot       = (slot_sum >= SW'(QUEUE_DEPTH)) ? AW'(slot_sum - SW'(QUEUE_DEPTH))
                                                  : AW'(slot_sum);
      head_inc   = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      seed_load  = csr_write_enable && (csr_index == gedc_pkg::CSR_SEED);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gedc_pkg::ST_IDLE: begin
            if (accept) begin
               case (req.func)
                  gedc_pkg::FUNC_CLEAR:    state_in = gedc_pkg::ST_FINISH;
                  gedc_pkg::FUNC_TRANSMIT: state_in = gedc_pkg::ST_DRAW_STATE;
                  default:                 state_in = gedc_pkg::ST_READ;
               endcase
            end
         end
         gedc_pkg::ST_DRAW_STATE: begin
            if (draw_rsp.done) begin
               state_in = gedc_pkg::ST_DRAW_LOSS;
            end
         end
         gedc_pkg::ST_DRAW_LOSS: begin
            if (draw_rsp.done) begin
               state_in = (draw_rsp.hit || queue_full) ? gedc_pkg::ST_READ
                                                       : gedc_pkg::ST_PUSH;
            end
         end
         gedc_pkg::ST_PUSH: state_in = gedc_pkg::ST_READ;
         gedc_pkg::ST_READ: begin
            state_in = (fill_ff != '0 && count_ff < CW'(gedc_pkg::MAX_RESULTS))
                       ? gedc_pkg::ST_CHECK : gedc_pkg::ST_FINISH;
         end
         gedc_pkg::ST_CHECK: begin
            if (!due) begin
               state_in = gedc_pkg::ST_FINISH;
            end else if (!hold_v_ff || out_free) begin
               state_in = gedc_pkg::ST_READ;
            end
         end
         gedc_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = gedc_pkg::ST_IDLE;
            end
         end
         default: state_in = gedc_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req.ready      = (state_ff == gedc_pkg::ST_IDLE) && !draw_rsp.busy;
      draw_req.start = 1'b0;
      draw_req.prob  = bad_ff ? p_b2g_ff : p_g2b_ff;
      q_we           = 1'b0;
      take           = 1'b0;
      emit_final     = 1'b0;
      case (state_ff)
         gedc_pkg::ST_IDLE: begin
            draw_req.start = accept && (req.func == gedc_pkg::FUNC_TRANSMIT);
         end
         gedc_pkg::ST_DRAW_STATE: begin
            // loss draw uses the state just reached
            draw_req.start = draw_rsp.done;
            draw_req.prob  = bad_next ? loss_bad_ff : loss_good_ff;
         end
         gedc_pkg::ST_PUSH:   q_we = 1'b1;
         gedc_pkg::ST_CHECK:  take = due && (!hold_v_ff || out_free);
         gedc_pkg::ST_FINISH: emit_final = out_free;
         default: begin
         end
      endcase
      emit_hold = take && hold_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_g2b_ff     <= '0;
         p_b2g_ff     <= PW'(64'h1_0000_0000);
         loss_good_ff <= '0;
         loss_bad_ff  <= '0;
         delay_ff     <= '0;
         seed_ff      <= gedc_pkg::TW_DEF_SEED;
         state_ff     <= gedc_pkg::ST_IDLE;
         bad_ff       <= 1'b0;
         lost_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         head_ff      <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               gedc_pkg::CSR_PROB_G2B:  p_g2b_ff     <= csr_write_data[PW-1:0];
               gedc_pkg::CSR_PROB_B2G:  p_b2g_ff     <= csr_write_data[PW-1:0];
               gedc_pkg::CSR_LOSS_GOOD: loss_good_ff <= csr_write_data[PW-1:0];
               gedc_pkg::CSR_LOSS_BAD:  loss_bad_ff  <= csr_write_data[PW-1:0];
               gedc_pkg::CSR_DELAY:     delay_ff     <= csr_write_data[15:0];
               gedc_pkg::CSR_SEED:      seed_ff      <= csr_write_data;
               default: begin
               end
            endcase
         end

         state_ff <= state_in;

         if (accept) begin
            lost_ff  <= 1'b0;
            ovf_ff   <= 1'b0;
            count_ff <= '0;
            if (req.func == gedc_pkg::FUNC_CLEAR) begin
               head_ff <= '0;
               fill_ff <= '0;
               bad_ff  <= 1'b0;
            end
         end

         if (state_ff == gedc_pkg::ST_DRAW_STATE && draw_rsp.done) begin
            bad_ff <= bad_next;
         end
         if (state_ff == gedc_pkg::ST_DRAW_LOSS && draw_rsp.done) begin
            lost_ff <= draw_rsp.hit;
            ovf_ff  <= !draw_rsp.hit && queue_full;
         end
         if (q_we) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (take) begin
            hold_v_ff <= 1'b1;
            head_ff   <= head_inc;
            fill_ff   <= fill_ff - 1'b1;
            count_ff  <= count_ff + 1'b1;
         end else if (emit_final) begin
            hold_v_ff <= 1'b0;
         end

         if (emit_hold || emit_final) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      func_ff <= accept ? req.func : func_ff;
      if (accept) begin
         step_ff <= req.step_number;
         tag_ff  <= req.payload_tag;
      end
      if (take) begin
         hold_arr_ff  <= q_arr;
         hold_pay_ff  <= q_rdata[31:0];
         hold_fill_ff <= fill_ff - 1'b1;
      end
      if (emit_hold || emit_final) begin
         rsp_delivered_ff <= hold_v_ff;
         rsp_arr_ff       <= hold_v_ff ? hold_arr_ff : 32'd0;
         rsp_pay_ff       <= hold_v_ff ? hold_pay_ff : 32'd0;
         rsp_pending_ff   <= hold_v_ff ? hold_fill_ff : fill_ff;
         rsp_last_ff      <= emit_final;
         rsp_bad_ff       <= bad_ff;
         rsp_lost_ff      <= lost_ff && (func_ff == gedc_pkg::FUNC_TRANSMIT);
         rsp_ovf_ff       <= ovf_ff && (func_ff == gedc_pkg::FUNC_TRANSMIT);
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.delivered      = rsp_delivered_ff;
   assign rsp.arrive_step    = rsp_arr_ff;
   assign rsp.payload_out    = rsp_pay_ff;
   assign rsp.last_of_run    = rsp_last_ff;
   assign rsp.channel_bad    = rsp_bad_ff;
   assign rsp.packet_lost    = rsp_lost_ff;
   assign rsp.queue_overflow = rsp_ovf_ff;
   assign rsp.in_flight      = rsp_pending_ff;
endmodule

// ===== hdl/gedc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module gedc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/gedc_twister.sv =====
// 64-bit Mersenne twister draw unit: state words in a RAM, seeded word by word
// and twisted lazily one word per draw. Uses gedc_pkg and gedc_ram.
module gedc_twister (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       seed_load,
   input  logic [63:0]                seed,
   input  gedc_pkg::gedc_draw_req_type draw_req,
   output gedc_pkg::gedc_draw_rsp_type draw_rsp
);
   localparam int IW = gedc_pkg::TW_IDX_W;

   gedc_pkg::gedc_tw_state_type state_ff, state_in;

   logic [IW-1:0] index_ff, index_in;
   logic [63:0]   prev_ff, prev_in;
   logic [63:0]   pp0_ff, pp0_in;
   logic [31:0]   pp1_ff, pp1_in;
   logic [31:0]   pp2_ff, pp2_in;
   logic [63:0]   wa_ff, wa_in;
   logic [63:0]   wb_ff, wb_in;
   logic [gedc_pkg::PROB_W-1:0] prob_ff, prob_in;
   logic          done_ff, done_in;
   logic          hit_ff, hit_in;

   logic          ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [63:0]   ram_wdata, ram_rdata;

   logic [IW-1:0] idx_next, idx_far;
   logic [63:0]   seed_eff, mix, seed_val, y, twisted, z;

   function automatic logic [63:0] temper(input logic [63:0] v);
      logic [63:0] t;
      t = v;
      t = t ^ ((t >> 29) & 64'h5555_5555_5555_5555);
      t = t ^ ((t << 17) & 64'h71D6_7FFF_EDA6_0000);
      t = t ^ ((t << 37) & 64'hFFF7_EEE0_0000_0000);
      t = t ^ (t >> 43);
      return t;
   endfunction

   gedc_ram #(.WIDTH(64), .DEPTH(gedc_pkg::TW_N)) u_words (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      idx_next = (index_ff == IW'(gedc_pkg::TW_N - 1)) ? '0 : index_ff + 1'b1;
      idx_far  = (index_ff < IW'(gedc_pkg::TW_M)) ? index_ff + IW'(gedc_pkg::TW_M)
                                                  : index_ff - IW'(gedc_pkg::TW_M);
      seed_eff = (seed == '0) ? gedc_pkg::TW_DEF_SEED : seed;
      mix      = prev_ff ^ (prev_ff >> 62);
      seed_val = pp0_ff + {pp1_ff + pp2_ff, 32'd0} + 64'(index_ff);
      // upper 33 bits of this word, lower 31 of the next; next is the fresh word 0 at the end
      y        = {wa_ff[63:31], wb_ff[30:0]};
      twisted  = ram_rdata ^ (y >> 1) ^ (y[0] ? gedc_pkg::TW_MATRIX : 64'd0);
      z        = temper(twisted);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gedc_pkg::TW_SEED_INIT:    state_in = gedc_pkg::TW_MUL_LO_ST;
         gedc_pkg::TW_MUL_LO_ST:    state_in = gedc_pkg::TW_MUL_MID_ST;
         gedc_pkg::TW_MUL_MID_ST:   state_in = gedc_pkg::TW_MUL_CROSS_ST;
         gedc_pkg::TW_MUL_CROSS_ST: state_in = gedc_pkg::TW_SEED_WRITE;
         gedc_pkg::TW_SEED_WRITE: begin
            state_in = (index_ff == IW'(gedc_pkg::TW_N - 1)) ? gedc_pkg::TW_IDLE
                                                             : gedc_pkg::TW_MUL_LO_ST;
         end
         gedc_pkg::TW_IDLE: begin
            if (draw_req.start) begin
               state_in = gedc_pkg::TW_READ_SELF;
            end
         end
         gedc_pkg::TW_READ_SELF: state_in = gedc_pkg::TW_READ_NEXT;
         gedc_pkg::TW_READ_NEXT: state_in = gedc_pkg::TW_READ_FAR;
         gedc_pkg::TW_READ_FAR:  state_in = gedc_pkg::TW_UPDATE;
         gedc_pkg::TW_UPDATE:    state_in = gedc_pkg::TW_IDLE;
         default:                state_in = gedc_pkg::TW_IDLE;
      endcase
      if (seed_load) begin
         state_in = gedc_pkg::TW_SEED_INIT;
      end
   end

   // datapath and RAM control
   always_comb begin
      index_in  = index_ff;
      prev_in   = prev_ff;
      pp0_in    = pp0_ff;
      pp1_in    = pp1_ff;
      pp2_in    = pp2_ff;
      wa_in     = wa_ff;
      wb_in     = wb_ff;
      prob_in   = prob_ff;
      done_in   = 1'b0;
      hit_in    = hit_ff;
      ram_we    = 1'b0;
      ram_waddr = index_ff;
      ram_wdata = seed_val;
      ram_raddr = index_ff;
      case (state_ff)
         gedc_pkg::TW_SEED_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = seed_eff;
            prev_in   = seed_eff;
            index_in  = IW'(1);
         end
         gedc_pkg::TW_MUL_LO_ST: begin
            pp0_in = 64'(mix[31:0]) * 64'(gedc_pkg::TW_MUL_LO);
         end
         gedc_pkg::TW_MUL_MID_ST: begin
            pp1_in = 32'(mix[63:32] * gedc_pkg::TW_MUL_LO);
         end
         gedc_pkg::TW_MUL_CROSS_ST: begin
            pp2_in = 32'(mix[31:0] * gedc_pkg::TW_MUL_HI);
         end
         gedc_pkg::TW_SEED_WRITE: begin
            ram_we   = 1'b1;
            prev_in  = seed_val;
            index_in = (index_ff == IW'(gedc_pkg::TW_N - 1)) ? '0 : index_ff + 1'b1;
         end
         gedc_pkg::TW_IDLE: begin
            if (draw_req.start) begin
               prob_in = draw_req.prob;
            end
         end
         gedc_pkg::TW_READ_SELF: begin
            ram_raddr = index_ff;
         end
         gedc_pkg::TW_READ_NEXT: begin
            ram_raddr = idx_next;
            wa_in     = ram_rdata;
         end
         gedc_pkg::TW_READ_FAR: begin
            ram_raddr = idx_far;
            wb_in     = ram_rdata;
         end
         gedc_pkg::TW_UPDATE: begin
            ram_we    = 1'b1;
            ram_wdata = twisted;
            index_in  = idx_next;
            hit_in    = {1'b0, z[63:32]} < prob_ff;
            done_in   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gedc_pkg::TW_SEED_INIT;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      index_ff <= index_in;
      prev_ff  <= prev_in;
      pp0_ff   <= pp0_in;
      pp1_ff   <= pp1_in;
      pp2_ff   <= pp2_in;
      wa_ff    <= wa_in;
      wb_ff    <= wb_in;
      prob_ff  <= prob_in;
      hit_ff   <= hit_in;
   end

   assign draw_rsp.busy = (state_ff != gedc_pkg::TW_IDLE);
   assign draw_rsp.done = done_ff;
   assign draw_rsp.hit  = hit_ff;
endmodule

// ===== sim/tb_top.sv =====
// Testbench for gilbert_elliott_delay_channel_unit: directed and random items with an
// in-bench Markov, twister and delay-queue predictor. Depends on gedc_pkg, gedc_req_if,
// gedc_rsp_if and the unit itself.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = 16;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE     = 40;

   typedef struct packed {
      bit        delivered;
      bit [31:0] arrive_step;
      bit [31:0] payload_out;
      bit        last_of_run;
      bit        channel_bad;
      bit        packet_lost;
      bit        queue_overflow;
      bit [4:0]  in_flight;
   } chan_result_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [gedc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [gedc_pkg::CSR_DATA_W-1:0]  csr_write_data;

   gedc_req_if req ();
   gedc_rsp_if #(.FILL_W(5)) rsp ();

   gilbert_elliott_delay_channel_unit #(.QUEUE_DEPTH(DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // predictor state
   bit [32:0] p_g2b, p_b2g, p_loss_good, p_loss_bad;
   bit [15:0] delay_cfg;
   bit        chan_bad;
   bit [63:0] tw_words [gedc_pkg::TW_N];
   int        tw_pos;
   bit [31:0] q_arrival [DEPTH];
   bit [31:0] q_payload [DEPTH];
   int        q_head, q_fill;

   chan_result_type expected_results[$];
   int  error_count = 0;
   int  sender_idle_pct, receiver_stall_pct;
   int  quiet_cycles = 0;
   bit [30:0] cur_step;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic void tw_reseed(input bit [63:0] seed);
      bit [63:0] prev;
      tw_words[0] = (seed == 64'd0) ? gedc_pkg::TW_DEF_SEED : seed;
      for (int i = 1; i < gedc_pkg::TW_N; i++) begin
         prev = tw_words[i-1];
         tw_words[i] = 64'd6364136223846793005 * (prev ^ (prev >> 62)) + 64'(i);
      end
      tw_pos = gedc_pkg::TW_N;
   endfunction

   function automatic bit [63:0] tw_output();
      bit [63:0] y, v, z;
      if (tw_pos >= gedc_pkg::TW_N) begin
         for (int i = 0; i < gedc_pkg::TW_N; i++) begin
            y = (tw_words[i] & 64'hFFFF_FFFF_8000_0000) |
                (tw_words[(i + 1) % gedc_pkg::TW_N] & 64'h7FFF_FFFF);
            v = tw_words[(i + gedc_pkg::TW_M) % gedc_pkg::TW_N] ^ (y >> 1);
            if (y[0]) v ^= gedc_pkg::TW_MATRIX;
            tw_words[i] = v;
         end
         tw_pos = 0;
      end
      z = tw_words[tw_pos];
      tw_pos++;
      z ^= (z >> 29) & 64'h5555_5555_5555_5555;
      z ^= (z << 17) & 64'h71D6_7FFF_EDA6_0000;
      z ^= (z << 37) & 64'hFFF7_EEE0_0000_0000;
      z ^= z >> 43;
      return z;
   endfunction

   function automatic bit chance(input bit [32:0] prob);
      bit [63:0] z;
      z = tw_output();
      return {1'b0, z[63:32]} < prob;
   endfunction

   function automatic chan_result_type make_result(input bit dlv, input bit [31:0] arr,
                                                   input bit [31:0] pay, input bit lost,
                                                   input bit ovf);
      chan_result_type r;
      r.delivered = dlv;
      r.arrive_step = arr;
      r.payload_out = pay;
      r.last_of_run = 1'b0;
      r.channel_bad = chan_bad;
      r.packet_lost = lost;
      r.queue_overflow = ovf;
      r.in_flight = 5'(q_fill);
      return r;
   endfunction

   // works out every result one accepted item causes
   function automatic void predict_channel(input bit [1:0] fn, input bit [30:0] step,
                                           input bit [31:0] tag);
      chan_result_type run[$];
      chan_result_type r;
      bit lost, ovf;
      int slot;
      lost = 1'b0;
      ovf = 1'b0;
      if (fn == gedc_pkg::FUNC_CLEAR) begin
         q_head = 0;
         q_fill = 0;
         chan_bad = 1'b0;
         r = make_result(1'b0, 32'd0, 32'd0, 1'b0, 1'b0);
         r.last_of_run = 1'b1;
         expected_results.insert(expected_results.size(), r);
         return;
      end
      if (fn == gedc_pkg::FUNC_TRANSMIT) begin
         if (!chan_bad) begin
            if (chance(p_g2b)) chan_bad = 1'b1;
         end else begin
            if (chance(p_b2g)) chan_bad = 1'b0;
         end
         lost = chance(chan_bad ? p_loss_bad : p_loss_good);
         if (!lost) begin
            if (q_fill >= DEPTH) begin
               ovf = 1'b1;
            end else begin
               slot = (q_head + q_fill) % DEPTH;
               q_arrival[slot] = {1'b0, step} + {16'd0, delay_cfg};
               q_payload[slot] = tag;
               q_fill++;
            end
         end
      end
      while (run.size() < gedc_pkg::MAX_RESULTS && q_fill > 0 &&
             q_arrival[q_head] <= {1'b0, step}) begin
         slot = q_head;
         q_head = (q_head + 1) % DEPTH;
         q_fill--;
         run.insert(run.size(),
                    make_result(1'b1, q_arrival[slot], q_payload[slot], lost, ovf));
      end
      if (run.size() == 0) run.insert(0, make_result(1'b0, 32'd0, 32'd0, lost, ovf));
      run[run.size()-1].last_of_run = 1'b1;
      foreach (run[i]) expected_results.insert(expected_results.size(), run[i]);
   endfunction

   // acceptance on both channels, checking and watchdog
   always @(posedge clock) begin
      chan_result_type want;
      if (!reset) begin
         if (req.valid && req.ready) predict_channel(req.func, req.step_number, req.payload_tag);
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result item", 32'd0, 32'd0);
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (rsp.delivered !== want.delivered)
                  report_mismatch("delivered", 32'(rsp.delivered), 32'(want.delivered));
               if (rsp.arrive_step !== want.arrive_step)
                  report_mismatch("arrive_step", rsp.arrive_step, want.arrive_step);
               if (rsp.payload_out !== want.payload_out)
                  report_mismatch("payload_out", rsp.payload_out, want.payload_out);
               if (rsp.last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", 32'(rsp.last_of_run), 32'(want.last_of_run));
               if (rsp.channel_bad !== want.channel_bad)
                  report_mismatch("channel_bad", 32'(rsp.channel_bad), 32'(want.channel_bad));
               if (rsp.packet_lost !== want.packet_lost)
                  report_mismatch("packet_lost", 32'(rsp.packet_lost), 32'(want.packet_lost));
               if (rsp.queue_overflow !== want.queue_overflow)
                  report_mismatch("queue_overflow", 32'(rsp.queue_overflow),
                                  32'(want.queue_overflow));
               if (rsp.in_flight !== want.in_flight)
                  report_mismatch("in_flight", 32'(rsp.in_flight), 32'(want.in_flight));
            end
         end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      rsp.ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);

   task automatic send_item(input bit [1:0] fn, input bit [30:0] step, input bit [31:0] tag);
      while ($urandom_range(99) < sender_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.func <= fn;
      req.step_number <= step;
      req.payload_tag <= tag;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [gedc_pkg::CSR_INDEX_W-1:0] idx,
                            input bit [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         gedc_pkg::CSR_PROB_G2B:  p_g2b = data[32:0];
         gedc_pkg::CSR_PROB_B2G:  p_b2g = data[32:0];
         gedc_pkg::CSR_LOSS_GOOD: p_loss_good = data[32:0];
         gedc_pkg::CSR_LOSS_BAD:  p_loss_bad = data[32:0];
         gedc_pkg::CSR_DELAY:     delay_cfg = data[15:0];
         gedc_pkg::CSR_SEED:      tw_reseed(data);
         default: ;
      endcase
   endtask

   task automatic configure(input bit [32:0] g2b, input bit [32:0] b2g, input bit [32:0] lg,
                            input bit [32:0] lb, input bit [15:0] dly);
      write_reg(gedc_pkg::CSR_PROB_G2B, 64'(g2b));
      write_reg(gedc_pkg::CSR_PROB_B2G, 64'(b2g));
      write_reg(gedc_pkg::CSR_LOSS_GOOD, 64'(lg));
      write_reg(gedc_pkg::CSR_LOSS_BAD, 64'(lb));
      write_reg(gedc_pkg::CSR_DELAY, 64'(dly));
      csr_write_enable <= 1'b0;
   endtask

   task automatic reseed(input bit [63:0] seed);
      write_reg(gedc_pkg::CSR_SEED, seed);
      csr_write_enable <= 1'b0;
   endtask

   // reset settings: no loss, no delay, every packet comes straight back
   task automatic test_field_extremes();
      send_item(gedc_pkg::FUNC_TRANSMIT, 31'd0, 32'd0);
      send_item(gedc_pkg::FUNC_TRANSMIT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(gedc_pkg::FUNC_FLUSH, 31'h5555_5555, 32'hAAAA_AAAA);
      send_item(gedc_pkg::FUNC_SPARE, 31'h2AAA_AAAA, 32'h5555_5555);
      send_item(gedc_pkg::FUNC_CLEAR, 31'd7, 32'h1234_5678);
      wait_drained();
   endtask

   // long delay fills the queue, then a late flush drains all of it at once
   task automatic test_queue_full();
      configure(33'd0, 33'h1_0000_0000, 33'd0, 33'd0, 16'hFFFF);
      for (int i = 0; i < 18; i++)
         send_item(gedc_pkg::FUNC_TRANSMIT, 31'(100 + i), $urandom);
      send_item(gedc_pkg::FUNC_FLUSH, 31'h7FFF_FFFF, 32'd0);
      send_item(gedc_pkg::FUNC_TRANSMIT, 31'd5, 32'hCAFE_0001);
      send_item(gedc_pkg::FUNC_CLEAR, 31'd5, 32'd0);
      send_item(gedc_pkg::FUNC_FLUSH, 31'h7FFF_FFFF, 32'd0);
      wait_drained();
   endtask

   // chain always flips, loss always fires in bad, above-one probability included
   task automatic test_markov_extremes();
      configure(33'h1_FFFF_FFFF, 33'h1_0000_0000, 33'd0, 33'h1_0000_0000, 16'd0);
      reseed(64'd0);
      for (int i = 0; i < 6; i++) send_item(gedc_pkg::FUNC_TRANSMIT, 31'(i), $urandom);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      int r;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         cur_step = cur_step + 31'($urandom_range(0, 3));
         if (i == count / 2) wait_drained();
         if (r < 68) send_item(gedc_pkg::FUNC_TRANSMIT, cur_step, $urandom);
         else if (r < 82) send_item(gedc_pkg::FUNC_FLUSH, cur_step, $urandom);
         else if (r < 86) send_item(gedc_pkg::FUNC_CLEAR, cur_step, $urandom);
         else if (r < 90) send_item(gedc_pkg::FUNC_SPARE, cur_step, $urandom);
         else send_item(2'($urandom_range(0, 3)), 31'($urandom), $urandom);
      end
      wait_drained();
   endtask

   initial begin
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      cur_step = 31'd0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req.valid = 1'b0;
      req.func = gedc_pkg::FUNC_FLUSH;
      req.step_number = '0;
      req.payload_tag = '0;
      p_g2b = 33'd0;
      p_b2g = 33'h1_0000_0000;
      p_loss_good = 33'd0;
      p_loss_bad = 33'd0;
      delay_cfg = 16'd0;
      chan_bad = 1'b0;
      q_head = 0;
      q_fill = 0;
      tw_reseed(gedc_pkg::TW_DEF_SEED);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_queue_full();
      test_markov_extremes();

      configure(33'h4000_0000, 33'h8000_0000, 33'h1000_0000, 33'h8000_0000, 16'd3);
      reseed(64'hFFFF_FFFF_FFFF_FFFF);
      test_random_traffic(25, 0, 0);

      configure(33'h2000_0000, 33'h4000_0000, 33'd0, 33'h6000_0000, 16'd9);
      reseed({$urandom, $urandom});
      test_random_traffic(25, 56, 0);

      cur_step = 31'h7FFF_FF00;
      configure(33'h8000_0000, 33'h2000_0000, 33'h0800_0000, 33'hFFFF_FFFF, 16'd1);
      test_random_traffic(25, 0, 56);

      configure(33'h1_0000_0000, 33'd0, 33'h1_FFFF_FFFF, 33'd0, 16'd20);
      reseed(64'd1);
      configure(33'h3000_0000, 33'h5000_0000, 33'h0400_0000, 33'h9000_0000, 16'd2);
      test_random_traffic(22, 9, 9);

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
